// ===== hw/rtl/aabb_cull_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_cull_pkg
// Shared types and constants for the box versus frustum culling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_cull_pkg;

  // planes held in configuration and planes actually tested
  localparam int PLANE_REGS  = 6;
  localparam int PLANE_SLOTS = 6;

  localparam int FIELD_W  = 16;               // one packed plane field
  localparam int PLANE_W  = 4 * FIELD_W;      // a, b, c, d
  localparam int SIZE_W   = 15;
  localparam int COUNT_W  = 3;
  localparam int COORD_W  = 18;               // corner coordinate, Q.4
  localparam int PROD_W   = FIELD_W + COORD_W;
  localparam int DSHIFT   = 14;               // align d (Q.4) to Q.18
  localparam int SUM_W    = PROD_W + 2;

  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 3;   // 8 bytes per register
  localparam int PDATA_W   = PLANE_W;

  typedef logic [PLANE_W-1:0]                 plane_t;
  typedef plane_t [PLANE_REGS-1:0]            plane_arr_t;
  typedef logic signed [COORD_W-1:0]          coord_t;
  typedef coord_t [2:0]                       corner_t;
  typedef corner_t [PLANE_SLOTS-1:0]          corner_arr_t;

  // stage load enables handed to the datapath blocks
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // coefficient k (0 = a, 1 = b, 2 = c, 3 = d) of a packed plane
  function automatic logic signed [FIELD_W-1:0] plane_field(input plane_t p,
                                                            input int k);
    plane_field = $signed(p[k*FIELD_W +: FIELD_W]);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aabb_cull_sel.sv =====
// ----------------------------------------------------------------------------
// aabb_cull_sel
// Stage 1: for each plane, picks the box corner farthest along its normal.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_cull_sel (
  input  wire logic                                    clk,
  input  wire aabb_cull_pkg::stage_en_t                en,
  input  wire aabb_cull_pkg::plane_arr_t               planes,
  input  wire logic signed [aabb_cull_pkg::FIELD_W-1:0] origin_x,
  input  wire logic signed [aabb_cull_pkg::FIELD_W-1:0] origin_y,
  input  wire logic signed [aabb_cull_pkg::FIELD_W-1:0] origin_z,
  input  wire logic        [aabb_cull_pkg::SIZE_W-1:0]  size_x,
  input  wire logic        [aabb_cull_pkg::SIZE_W-1:0]  size_y,
  input  wire logic        [aabb_cull_pkg::SIZE_W-1:0]  size_z,
  output aabb_cull_pkg::corner_arr_t                   corner_r
);

  localparam int CW = aabb_cull_pkg::COORD_W;

  logic signed [CW-1:0] lo [3];
  logic signed [CW-1:0] hi [3];
  aabb_cull_pkg::corner_arr_t corner_nxt;

  always_comb begin
    lo[0] = CW'(origin_x);
    lo[1] = CW'(origin_y);
    lo[2] = CW'(origin_z);
    hi[0] = lo[0] + $signed({{(CW-aabb_cull_pkg::SIZE_W){1'b0}}, size_x});
    hi[1] = lo[1] + $signed({{(CW-aabb_cull_pkg::SIZE_W){1'b0}}, size_y});
    hi[2] = lo[2] + $signed({{(CW-aabb_cull_pkg::SIZE_W){1'b0}}, size_z});
  end

  // a negative coefficient is largest at the low end of the axis
  always_comb begin
    for (int p = 0; p < aabb_cull_pkg::PLANE_SLOTS; p++) begin
      for (int k = 0; k < 3; k++) begin
        corner_nxt[p][k] = aabb_cull_pkg::plane_field(planes[p], k) < 0 ? lo[k] : hi[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      corner_r <= corner_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_cull_mac.sv =====
// ----------------------------------------------------------------------------
// aabb_cull_mac
// Stages 2 and 3 for one plane: products, then signed distance sign.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_cull_mac (
  input  wire logic                       clk,
  input  wire aabb_cull_pkg::stage_en_t   en,
  input  wire aabb_cull_pkg::plane_t      plane,
  input  wire aabb_cull_pkg::corner_t     corner,
  output logic                            behind_r
);

  localparam int PW = aabb_cull_pkg::PROD_W;
  localparam int SW = aabb_cull_pkg::SUM_W;
  localparam int FW = aabb_cull_pkg::FIELD_W;

  logic signed [PW-1:0] prod_r   [3];
  logic signed [PW-1:0] prod_nxt [3];
  logic signed [FW-1:0] d_r;
  logic signed [SW-1:0] dist_sum;
  logic signed [SW-1:0] d_ext;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = PW'(aabb_cull_pkg::plane_field(plane, k)) * PW'($signed(corner[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r <= prod_nxt;
      d_r    <= aabb_cull_pkg::plane_field(plane, 3);
    end
  end

  always_comb begin
    d_ext    = SW'(d_r) <<< aabb_cull_pkg::DSHIFT;
    dist_sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + d_ext;
  end

  // farthest corner still negative: whole box behind this plane
  always_ff @(posedge clk) begin
    if (en.s3) begin
      behind_r <= dist_sum[SW-1];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_frustum_cull_test_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit
// Axis-aligned box versus view-frustum test, four-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The six planes (near, right, left, top, bottom, far) are written over the
//   APB port, one 64-bit register per plane at byte address 8*i; the user must
//   write them only while the unit is idle, which the block does not enforce.
//   Each input word carries a box (origin, size) and a plane count; each
//   output word carries one visible bit. Between acceptance and out_valid, the
//   corner select register loads at the accepting edge, then products,
//   distance sum and sign, then the decision into the output register. One
//   word is accepted every cycle while in_stall is low; the rate is set by the
//   three 16x18 multipliers per plane, one set of 18 working in parallel.
//   Valid bits travel with each stage, and a stage loads when it is empty
//   or its successor moves, so bubbles close up under a stall. in_stall
//   rises only once all four stages hold words and out_stall is high.
//   Reset clears the stage valid bits and all plane registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_frustum_cull_test_unit (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  // input channel
  input  wire logic                                        in_valid,
  output logic                                             in_stall,
  input  wire logic signed [aabb_cull_pkg::FIELD_W-1:0]    in_origin_x,
  input  wire logic signed [aabb_cull_pkg::FIELD_W-1:0]    in_origin_y,
  input  wire logic signed [aabb_cull_pkg::FIELD_W-1:0]    in_origin_z,
  input  wire logic        [aabb_cull_pkg::SIZE_W-1:0]     in_size_x,
  input  wire logic        [aabb_cull_pkg::SIZE_W-1:0]     in_size_y,
  input  wire logic        [aabb_cull_pkg::SIZE_W-1:0]     in_size_z,
  input  wire logic        [aabb_cull_pkg::COUNT_W-1:0]    in_plane_count,
  // result channel
  output logic                                             out_valid,
  input  wire logic                                        out_stall,
  output logic                                             out_visible,
  // configuration
  input  wire logic                                        psel,
  input  wire logic                                        penable,
  input  wire logic                                        pwrite,
  input  wire logic        [aabb_cull_pkg::PADDR_W-1:0]    paddr,
  input  wire logic        [aabb_cull_pkg::PDATA_W-1:0]    pwdata,
  output logic             [aabb_cull_pkg::PDATA_W-1:0]    prdata,
  output logic                                             pready
);

  localparam int NP = aabb_cull_pkg::PLANE_SLOTS;
  localparam int CNW = aabb_cull_pkg::COUNT_W;

  aabb_cull_pkg::plane_arr_t  planes_r;
  aabb_cull_pkg::corner_arr_t corner_r;
  aabb_cull_pkg::stage_en_t   en;

  logic [aabb_cull_pkg::REG_IDX_W-1:0] reg_idx;
  logic [NP-1:0]  behind_r;
  logic [NP-1:0]  use_mask;
  logic           v1_r, v2_r, v3_r, out_valid_r;
  logic [CNW-1:0] cnt1_r, cnt2_r, cnt3_r;
  logic           out_visible_r, out_visible_nxt;
  logic           rdy1, rdy2, rdy3, rdy_out;
  logic           count_ok;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[aabb_cull_pkg::PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      for (int i = 0; i < aabb_cull_pkg::PLANE_REGS; i++) begin
        if (32'(reg_idx) == i) begin
          planes_r[i] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < aabb_cull_pkg::PLANE_REGS; i++) begin
      if (32'(reg_idx) == i) begin
        prdata = planes_r[i];
      end
    end
  end

  // ---------------- flow control ----------------
  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1)    cnt1_r        <= in_plane_count;
    if (rdy2)    cnt2_r        <= cnt1_r;
    if (rdy3)    cnt3_r        <= cnt2_r;
    if (rdy_out) out_visible_r <= out_visible_nxt;
  end

  // ---------------- datapath ----------------
  aabb_cull_sel u_sel (
    .clk      (clk),
    .en       (en),
    .planes   (planes_r),
    .origin_x (in_origin_x),
    .origin_y (in_origin_y),
    .origin_z (in_origin_z),
    .size_x   (in_size_x),
    .size_y   (in_size_y),
    .size_z   (in_size_z),
    .corner_r (corner_r)
  );

  for (genvar p = 0; p < NP; p++) begin : g_plane
    aabb_cull_mac u_mac (
      .clk      (clk),
      .en       (en),
      .plane    (planes_r[p]),
      .corner   (corner_r[p]),
      .behind_r (behind_r[p])
    );
  end

  // planes past plane_count cannot reject; a count of 0 or 7 always rejects
  always_comb begin
    count_ok = (cnt3_r != '0) && (32'(cnt3_r) <= NP);
    for (int i = 0; i < NP; i++) begin
      use_mask[i] = 32'(cnt3_r) > i;
    end
    out_visible_nxt = count_ok && !(|(behind_r & use_mask));
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  // ---------------- checks ----------------
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy_out && (cnt3_r == '0 || 32'(cnt3_r) > NP)) |=> !out_visible)
    else $error("out of range plane count reported visible");

  a_near_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy_out && behind_r[0]) |=> !out_visible)
    else $error("box behind first plane reported visible");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy_out) |=> out_valid)
    else $error("word lost between last stage and output register");

endmodule

`default_nettype wire

// ===== bench/tb_aabb_frustum_cull_test_unit.sv =====
// ----------------------------------------------------------------------------
// tb_aabb_frustum_cull_test_unit
// Self-checking bench for the box versus frustum culling unit. The six
// planes are loaded over APB while the pipeline is empty, boxes are pushed
// through the input channel with random gaps, and every result word is
// compared with a visibility bit predicted from a local copy of the planes.
// ----------------------------------------------------------------------------
module tb_aabb_frustum_cull_test_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [aabb_cull_pkg::REG_IDX_W-1:0] {
    REG_NEAR,
    REG_RIGHT,
    REG_LEFT,
    REG_TOP,
    REG_BOTTOM,
    REG_FAR,
    REG_SPARE_6,
    REG_SPARE_7
  } plane_reg_t;

  typedef struct {
    logic signed [aabb_cull_pkg::FIELD_W-1:0] origin_x;
    logic signed [aabb_cull_pkg::FIELD_W-1:0] origin_y;
    logic signed [aabb_cull_pkg::FIELD_W-1:0] origin_z;
    logic        [aabb_cull_pkg::SIZE_W-1:0]  size_x;
    logic        [aabb_cull_pkg::SIZE_W-1:0]  size_y;
    logic        [aabb_cull_pkg::SIZE_W-1:0]  size_z;
    logic        [aabb_cull_pkg::COUNT_W-1:0] plane_count;
  } box_t;

  logic                                      clk;
  logic                                      rst_n;
  logic                                      in_valid;
  logic                                      in_stall;
  logic signed [aabb_cull_pkg::FIELD_W-1:0]  in_origin_x;
  logic signed [aabb_cull_pkg::FIELD_W-1:0]  in_origin_y;
  logic signed [aabb_cull_pkg::FIELD_W-1:0]  in_origin_z;
  logic        [aabb_cull_pkg::SIZE_W-1:0]   in_size_x;
  logic        [aabb_cull_pkg::SIZE_W-1:0]   in_size_y;
  logic        [aabb_cull_pkg::SIZE_W-1:0]   in_size_z;
  logic        [aabb_cull_pkg::COUNT_W-1:0]  in_plane_count;
  logic                                      out_valid;
  logic                                      out_stall;
  logic                                      out_visible;
  logic                                      psel;
  logic                                      penable;
  logic                                      pwrite;
  logic        [aabb_cull_pkg::PADDR_W-1:0]  paddr;
  logic        [aabb_cull_pkg::PDATA_W-1:0]  pwdata;
  logic        [aabb_cull_pkg::PDATA_W-1:0]  prdata;
  logic                                      pready;

  aabb_cull_pkg::plane_arr_t plane_mirror;
  logic        visible_q[$];
  logic        expected_visible;
  int unsigned fail_count;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          hold_cycles;

  aabb_frustum_cull_test_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_origin_z    (in_origin_z),
    .in_size_x      (in_size_x),
    .in_size_y      (in_size_y),
    .in_size_z      (in_size_z),
    .in_plane_count (in_plane_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_visible    (out_visible),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // box is dropped when its plane count is out of range or all eight corners are strictly behind any tested plane
  function automatic logic predict_visibility(box_t b);
    longint lo[3];
    longint hi[3];
    longint na, nb, nc, dd, dist_val;
    logic   behind;
    if (b.plane_count == 0 || b.plane_count > aabb_cull_pkg::PLANE_SLOTS) begin
      return 1'b0;
    end
    lo[0] = b.origin_x;
    lo[1] = b.origin_y;
    lo[2] = b.origin_z;
    hi[0] = lo[0] + longint'(b.size_x);
    hi[1] = lo[1] + longint'(b.size_y);
    hi[2] = lo[2] + longint'(b.size_z);
    for (int p = 0; p < int'(b.plane_count); p++) begin
      na = $signed(plane_mirror[p][15:0]);
      nb = $signed(plane_mirror[p][31:16]);
      nc = $signed(plane_mirror[p][47:32]);
      dd = $signed(plane_mirror[p][63:48]);
      dd = dd * 16384;
      behind = 1'b1;
      for (int k = 0; k < 8; k++) begin
        dist_val = na * (((k & 1) != 0) ? hi[0] : lo[0])
                 + nb * (((k & 2) != 0) ? hi[1] : lo[1])
                 + nc * (((k & 4) != 0) ? hi[2] : lo[2]) + dd;
        if (dist_val >= 0) begin
          behind = 1'b0;
        end
      end
      if (behind) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [aabb_cull_pkg::SIZE_W-1:0] random_size(int mode);
    case (mode)
      0:       return '0;
      1:       return aabb_cull_pkg::SIZE_W'($urandom);
      default: return aabb_cull_pkg::SIZE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic signed [aabb_cull_pkg::FIELD_W-1:0] random_coord();
    if ($urandom_range(0, 1) == 1) begin
      return aabb_cull_pkg::FIELD_W'($urandom);
    end
    return aabb_cull_pkg::FIELD_W'($urandom_range(0, 4095) - 2048);
  endfunction

  function automatic box_t random_box();
    box_t b;
    int   mode;
    mode = $urandom_range(0, 3);
    b.origin_x = random_coord();
    b.origin_y = random_coord();
    b.origin_z = random_coord();
    b.size_x   = random_size(mode);
    b.size_y   = random_size(mode);
    b.size_z   = random_size(mode);
    if ($urandom_range(0, 9) == 0) begin
      b.plane_count = ($urandom_range(0, 1) == 1) ?
                      aabb_cull_pkg::COUNT_W'(aabb_cull_pkg::PLANE_SLOTS + 1) : '0;
    end else begin
      b.plane_count = aabb_cull_pkg::COUNT_W'($urandom_range(1, aabb_cull_pkg::PLANE_SLOTS));
    end
    return b;
  endfunction

  function automatic aabb_cull_pkg::plane_t random_plane();
    aabb_cull_pkg::plane_t p;
    p = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       p = '0;
      1:       p = '1;
      2:       p = {4{16'h8000}};
      3:       p = {4{16'h7fff}};
      4:       p[63:48] = '0;       // plane through the origin
      default: ;
    endcase
    return p;
  endfunction

  function automatic box_t make_box(int ox, int oy, int oz, int sx, int sy, int sz,
                                    int count);
    box_t b;
    b.origin_x    = aabb_cull_pkg::FIELD_W'(ox);
    b.origin_y    = aabb_cull_pkg::FIELD_W'(oy);
    b.origin_z    = aabb_cull_pkg::FIELD_W'(oz);
    b.size_x      = aabb_cull_pkg::SIZE_W'(sx);
    b.size_y      = aabb_cull_pkg::SIZE_W'(sy);
    b.size_z      = aabb_cull_pkg::SIZE_W'(sz);
    b.plane_count = aabb_cull_pkg::COUNT_W'(count);
    return b;
  endfunction

  // receiver: random stall, or a long hold-off while hold_cycles runs down
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (visible_q.size() == 0) begin
        $error("unexpected result word, visible %0b", out_visible);
        fail_count++;
      end else begin
        expected_visible = visible_q.pop_front();
        if (out_visible !== expected_visible) begin
          $error("visible: expected %0b, actual %0b", expected_visible, out_visible);
          fail_count++;
        end
      end
    end
  end

  task automatic cfg_write(plane_reg_t idx, aabb_cull_pkg::plane_t value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (int'(idx) < aabb_cull_pkg::PLANE_REGS) begin
      plane_mirror[idx] = value;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_all_planes(aabb_cull_pkg::plane_t value);
    for (int i = 0; i < aabb_cull_pkg::PLANE_REGS; i++) begin
      cfg_write(plane_reg_t'(i), value);
    end
  endtask

  task automatic send_box(box_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_origin_x    <= b.origin_x;
    in_origin_y    <= b.origin_y;
    in_origin_z    <= b.origin_z;
    in_size_x      <= b.size_x;
    in_size_y      <= b.size_y;
    in_size_z      <= b.size_z;
    in_plane_count <= b.plane_count;
    do @(posedge clk); while (in_stall !== 1'b0);
    visible_q.push_back(predict_visibility(b));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (visible_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // all planes zero: every corner sits exactly on each plane
  task automatic test_reset_planes();
    for (int c = 0; c <= aabb_cull_pkg::PLANE_SLOTS + 1; c++) begin
      send_box(make_box(c * 100 - 300, 7, -9, c * 3, 0, 40, c));
    end
    wait_for_results();
  endtask

  // near plane x - 1.0 = 0: a corner exactly on it keeps the box
  task automatic test_zero_distance();
    cfg_write(REG_NEAR, {16'hfff0, 16'h0000, 16'h0000, 16'h4000});
    send_box(make_box(16, 0, 0, 0, 0, 0, 1));
    send_box(make_box(15, 0, 0, 0, 0, 0, 1));
    send_box(make_box(15, 0, 0, 1, 0, 0, 1));
    send_box(make_box(16, -500, 300, 0, 0, 0, aabb_cull_pkg::PLANE_SLOTS));
    wait_for_results();
  endtask

  // far plane rejects everything, so only counts that reach it drop the box
  task automatic test_plane_order();
    load_all_planes('0);
    cfg_write(REG_FAR, {16'hffff, 48'h0});
    send_box(make_box(1, 2, 3, 4, 5, 6, aabb_cull_pkg::PLANE_SLOTS - 1));
    send_box(make_box(1, 2, 3, 4, 5, 6, aabb_cull_pkg::PLANE_SLOTS));
    send_box(make_box(1, 2, 3, 4, 5, 6, aabb_cull_pkg::PLANE_SLOTS + 1));
    wait_for_results();
    // writes past the last plane must not disturb anything
    cfg_write(REG_SPARE_6, '1);
    cfg_write(REG_SPARE_7, '1);
    send_box(make_box(1, 2, 3, 4, 5, 6, aabb_cull_pkg::PLANE_SLOTS - 1));
    wait_for_results();
  endtask

  task automatic test_field_extremes();
    load_all_planes({4{16'h8000}});
    send_box(make_box(-32768, -32768, -32768, 0, 0, 0, aabb_cull_pkg::PLANE_SLOTS));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767,
                      aabb_cull_pkg::PLANE_SLOTS));
    wait_for_results();
    load_all_planes({4{16'h7fff}});
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767,
                      aabb_cull_pkg::PLANE_SLOTS));
    send_box(make_box(-32768, -32768, -32768, 0, 0, 0, aabb_cull_pkg::PLANE_SLOTS));
    wait_for_results();
  endtask

  task automatic run_random_phase(int src_pct, int sink_pct, int n_items);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 105 == 0) begin
        wait_for_results();
        for (int r = 0; r < aabb_cull_pkg::PLANE_REGS; r++) begin
          cfg_write(plane_reg_t'(r), random_plane());
        end
      end
      send_box(random_box());
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    run_random_phase(20, 86, 630);
    run_random_phase(86, 20, 630);
    run_random_phase(0, 0, 630);
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_output_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_cycles   = 64;
    repeat (24) send_box(random_box());
    wait_for_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_origin_x    = '0;
    in_origin_y    = '0;
    in_origin_z    = '0;
    in_size_x      = '0;
    in_size_y      = '0;
    in_size_z      = '0;
    in_plane_count = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    plane_mirror   = '0;
    fail_count     = 0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    hold_cycles    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_planes();
    test_zero_distance();
    test_plane_order();
    test_field_extremes();
    test_random_traffic();
    test_output_backpressure();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && visible_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
